FILE: sv/assert_macros.svh
// Assertion macros used by the connectivity engine's walker.
// Each macro expects a clock named clock and a synchronous reset named reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define QUC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define QUC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/quc_pkg.sv
// Shared types and constants for the quick-union connectivity engine.
// No dependencies; every module refers to this package by scoped names.
package quc_pkg;

   localparam int NumElems  = 256;
   localparam int ElemWidth = $clog2(NumElems);

   typedef logic [ElemWidth-1:0] elem_type;

   typedef struct packed {
      elem_type elem_p;
      elem_type elem_q;
   } quc_req_type;

   typedef struct packed {
      elem_type root_p;
      elem_type root_q;
      logic     already_joined;
   } quc_rsp_type;

   // Access bundle from the walker to the parent memory.
   typedef struct packed {
      elem_type rd_addr;
      logic     wr_en;
      elem_type wr_addr;
      elem_type wr_data;
   } quc_mem_req_type;

   typedef enum logic [1:0] {
      QUC_IDLE,
      QUC_WALK_P,
      QUC_WALK_Q
   } quc_state_type;

endpackage

FILE: sv/quick_union_connectivity.sv
// Quick-union connectivity engine.
// Each transfer on the req_ channel carries two element indices. The block walks the
// parent table from each element up to its root, reports both roots on the rsp_ channel,
// and links the first root under the second root when they differ. already_joined is set
// when both roots were the same, in which case the table is left unchanged.
// The pair is taken in the idle state, then each walk reads the parent table once per
// entry visited, up to and including its root. The parent memory has a single read port:
// each link followed is one read, and the next address is the data just read.
// One pair is worked on at a time; req_stall is high from acceptance until the result
// is loaded into the output register. The result register decouples the two sides, so
// a new pair is taken while a finished result still waits on rsp_stall. If the receiver
// stalls with the register full, the walker holds its root and waits.
// Reset is synchronous and active high. It empties the result register and returns the
// parent table to one element per set at once, through per-entry valid bits, so the
// block is ready in the first cycle after reset with no clearing pass.
// Depends on quc_pkg, quc_parent_mem and quc_walker.
module quick_union_connectivity (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  quc_pkg::quc_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output quc_pkg::quc_rsp_type rsp_data
);

   // Read address and link write from the sequencer to the table.
   quc_pkg::quc_mem_req_type mem_req;
   // Parent of the entry read in the previous cycle.
   quc_pkg::elem_type        rd_data;

   quc_walker u_walker (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .mem_req   (mem_req),
      .rd_data   (rd_data)
   );

   quc_parent_mem u_parent_mem (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

endmodule

FILE: sv/quc_parent_mem.sv
// Parent table: one synchronous memory with one read and one write port.
// Depends on quc_pkg. Entries never written read back as their own index.
module quc_parent_mem (
   input  logic                     clock,
   input  logic                     reset,
   input  quc_pkg::quc_mem_req_type mem_req,
   output quc_pkg::elem_type        rd_data
);

   quc_pkg::elem_type                mem_ff [quc_pkg::NumElems];
   logic [quc_pkg::NumElems-1:0]     valid_ff;
   quc_pkg::elem_type                rd_mem_ff;
   quc_pkg::elem_type                rd_addr_ff;
   logic                             rd_valid_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      rd_mem_ff  <= mem_ff[mem_req.rd_addr];
      rd_addr_ff <= mem_req.rd_addr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (mem_req.wr_en) begin
            valid_ff[mem_req.wr_addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[mem_req.rd_addr];
      end
   end

   // An entry that was never linked is a root: it points to itself.
   assign rd_data = rd_valid_ff ? rd_mem_ff : rd_addr_ff;

endmodule

FILE: sv/quc_walker.sv
// Root-walk sequencer and result register of the connectivity engine.
// Depends on quc_pkg and assert_macros.svh; drives the parent memory port.
`include "assert_macros.svh"

module quc_walker (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  quc_pkg::quc_req_type     req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output quc_pkg::quc_rsp_type     rsp_data,
   output quc_pkg::quc_mem_req_type mem_req,
   input  quc_pkg::elem_type        rd_data
);

   quc_pkg::quc_state_type state_ff, state_in;
   quc_pkg::elem_type      cur_ff, cur_in;
   quc_pkg::elem_type      elem_q_ff, elem_q_in;
   quc_pkg::elem_type      root_p_ff, root_p_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   quc_pkg::quc_rsp_type   rsp_data_ff, rsp_data_in;
   logic                   rsp_free;
   logic                   joined;

   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign joined   = (root_p_ff == cur_ff);

   always_comb begin
      state_in         = state_ff;
      cur_in           = cur_ff;
      elem_q_in        = elem_q_ff;
      root_p_in        = root_p_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_data_in      = rsp_data_ff;
      req_stall        = 1'b1;
      mem_req.rd_addr  = cur_ff;
      mem_req.wr_en    = 1'b0;
      mem_req.wr_addr  = root_p_ff;
      mem_req.wr_data  = cur_ff;
      unique case (state_ff)
         quc_pkg::QUC_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cur_in          = req_data.elem_p;
               elem_q_in       = req_data.elem_q;
               mem_req.rd_addr = req_data.elem_p;
               state_in        = quc_pkg::QUC_WALK_P;
            end
         end
         quc_pkg::QUC_WALK_P: begin
            if (rd_data == cur_ff) begin
               root_p_in       = cur_ff;
               cur_in          = elem_q_ff;
               mem_req.rd_addr = elem_q_ff;
               state_in        = quc_pkg::QUC_WALK_Q;
            end else begin
               cur_in          = rd_data;
               mem_req.rd_addr = rd_data;
            end
         end
         quc_pkg::QUC_WALK_Q: begin
            if (rd_data == cur_ff) begin
               // Root found; re-read it while the result register is still full.
               if (rsp_free) begin
                  rsp_valid_in               = 1'b1;
                  rsp_data_in.root_p         = root_p_ff;
                  rsp_data_in.root_q         = cur_ff;
                  rsp_data_in.already_joined = joined;
                  mem_req.wr_en              = !joined;
                  state_in                   = quc_pkg::QUC_IDLE;
               end
            end else begin
               cur_in          = rd_data;
               mem_req.rd_addr = rd_data;
            end
         end
         default: begin
            state_in = quc_pkg::QUC_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= quc_pkg::QUC_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      elem_q_ff   <= elem_q_in;
      root_p_ff   <= root_p_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `QUC_ASSERT_NOW(a_link_distinct, mem_req.wr_en, mem_req.wr_addr != mem_req.wr_data, "link written between equal roots")
   `QUC_ASSERT_NEXT(a_link_reports, mem_req.wr_en, rsp_valid && !rsp_data.already_joined, "link written without a matching unjoined result")
   `QUC_ASSERT_NEXT(a_accept_walks, req_valid && !req_stall, state_ff == quc_pkg::QUC_WALK_P, "accepted pair did not start the first walk")

endmodule
